// File: rtl/kwlm_pkg.sv
`timescale 1ns / 1ps

package kwlm_pkg;

    localparam int MAX_THREADS_DEF = 16;
    localparam int OBJ_W           = 16;
    localparam int VER_W           = 32;
    localparam int MOP_W           = 32;
    localparam int TID_W           = 4;
    localparam int KIND_W          = 3;
    localparam int CNT_W           = 32;
    localparam int TC_W            = 5;
    localparam int OC_W            = 17;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 17;

    localparam logic CMD_ENTRY = 1'b0;
    localparam logic CMD_END   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_THREAD_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENTRY = 3'd0,
        KIND_START = 3'd1,
        KIND_COUNT = 3'd2,
        KIND_GAP   = 3'd3,
        KIND_NONE  = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DECIDE,
        ST_COUNT,
        ST_GAP,
        ST_START,
        ST_ENTRY,
        ST_TCOUNT,
        ST_TGAP,
        ST_NONE
    } t_state;

    typedef struct packed {
        logic             cmd;
        logic [TID_W-1:0] tid;
        logic [OBJ_W-1:0] obj;
        logic [VER_W-1:0] ver;
        logic [MOP_W-1:0] mop;
    } t_item;

    typedef struct packed {
        t_kind            kind;
        logic [TID_W-1:0] thr;
        logic [VER_W-1:0] ver;
        logic [MOP_W-1:0] mop;
        logic [OBJ_W-1:0] first;
        logic [OBJ_W-1:0] lst;
        logic [CNT_W-1:0] idx;
        logic             fin;
    } t_rec;

endpackage

// File: rtl/kwlm_front.sv
`timescale 1ns / 1ps

module kwlm_front #(
    parameter int MAX_THREADS = kwlm_pkg::MAX_THREADS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [$clog2(MAX_THREADS+1)-1:0]       i_nt,
    input  logic                                   i_valid,
    input  kwlm_pkg::t_item                        i_item,
    output logic                                   o_stall,
    output logic                                   o_q_valid,
    output kwlm_pkg::t_item                        o_q_item,
    input  logic                                   i_q_pop
);

    localparam int CW = $clog2(MAX_THREADS+1);
    localparam int XW = (CW > kwlm_pkg::TID_W) ? CW : kwlm_pkg::TID_W;

    kwlm_pkg::t_item r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       in_range, push;

    // items for threads outside the live set change nothing: drop them here
    assign in_range  = XW'(i_item.tid) < XW'(i_nt);
    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall && in_range;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= !r_wptr;
            if (i_q_pop) r_rptr <= !r_rptr;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= i_item;
    end

endmodule

// File: rtl/kwlm_back.sv
`timescale 1ns / 1ps

module kwlm_back #(
    parameter int MAX_THREADS = kwlm_pkg::MAX_THREADS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [$clog2(MAX_THREADS+1)-1:0]       i_nt,
    input  logic [kwlm_pkg::OC_W-1:0]              i_object_count,
    input  logic                                   i_q_valid,
    input  kwlm_pkg::t_item                        i_q_item,
    output logic                                   o_q_pop,
    output logic                                   o_valid,
    output kwlm_pkg::t_rec                         o_rec,
    input  logic                                   i_stall
);

    localparam int CW = $clog2(MAX_THREADS+1);
    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int OW = kwlm_pkg::OBJ_W;
    localparam int NW = kwlm_pkg::CNT_W;

    kwlm_pkg::t_state r_state, n_state;

    logic [MAX_THREADS-1:0] r_hvalid, r_hended;
    logic [OW-1:0]              r_hobj [MAX_THREADS];
    logic [kwlm_pkg::VER_W-1:0] r_hver [MAX_THREADS];
    logic [kwlm_pkg::MOP_W-1:0] r_hmop [MAX_THREADS];

    logic [TW-1:0]              r_idx, r_best;
    logic                       r_found;
    logic [OW-1:0]              r_bobj;
    logic [kwlm_pkg::VER_W-1:0] r_bver;
    logic [kwlm_pkg::MOP_W-1:0] r_bmop;

    logic [OW-1:0] r_prev;
    logic          r_present;
    logic [NW-1:0] r_total, r_start;

    logic            r_out_valid;
    kwlm_pkg::t_rec  r_out, n_out;
    logic            load, out_free, clear;

    logic [MAX_THREADS-1:0] live;
    logic          all_ready, any_valid, better, scan_done, tail, gap_after;
    logic [TW-1:0] widx;
    logic [OW:0]   prev_inc, limit;

    always_comb begin
        for (int i = 0; i < MAX_THREADS; i++) begin
            live[i] = (CW'(i) < i_nt);
        end
    end

    assign all_ready = &(~live | r_hvalid | r_hended);
    assign any_valid = |(live & r_hvalid);
    assign widx      = TW'(i_q_item.tid);

    assign better = r_hvalid[r_idx] && (!r_found || r_hobj[r_idx] < r_bobj ||
                    (r_hobj[r_idx] == r_bobj && r_hver[r_idx] < r_bver));
    assign scan_done = (CW'(r_idx) == i_nt - CW'(1));

    assign prev_inc  = {1'b0, r_prev} + (OW+1)'(1);
    assign limit     = (i_object_count > kwlm_pkg::OC_W'(1 << OW)) ?
                       (OW+1)'(1 << OW) : (OW+1)'(i_object_count);
    assign tail      = prev_inc < limit;
    assign gap_after = {1'b0, r_bobj} > prev_inc;

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_rec    = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kwlm_pkg::ST_IDLE:   if (i_q_valid) n_state = kwlm_pkg::ST_CHECK;
            kwlm_pkg::ST_CHECK: begin
                if (!all_ready)     n_state = kwlm_pkg::ST_IDLE;
                else if (any_valid) n_state = kwlm_pkg::ST_SCAN;
                else if (r_present) n_state = kwlm_pkg::ST_TCOUNT;
                else                n_state = kwlm_pkg::ST_NONE;
            end
            kwlm_pkg::ST_SCAN:   if (scan_done) n_state = kwlm_pkg::ST_DECIDE;
            kwlm_pkg::ST_DECIDE: begin
                if (!r_present)
                    n_state = (r_bobj != '0) ? kwlm_pkg::ST_GAP : kwlm_pkg::ST_START;
                else
                    n_state = (r_bobj != r_prev) ? kwlm_pkg::ST_COUNT : kwlm_pkg::ST_ENTRY;
            end
            kwlm_pkg::ST_COUNT:
                if (out_free) n_state = gap_after ? kwlm_pkg::ST_GAP : kwlm_pkg::ST_START;
            kwlm_pkg::ST_GAP:    if (out_free) n_state = kwlm_pkg::ST_START;
            kwlm_pkg::ST_START:  if (out_free) n_state = kwlm_pkg::ST_ENTRY;
            kwlm_pkg::ST_ENTRY:  if (out_free) n_state = kwlm_pkg::ST_IDLE;
            kwlm_pkg::ST_TCOUNT:
                if (out_free) n_state = tail ? kwlm_pkg::ST_TGAP : kwlm_pkg::ST_IDLE;
            kwlm_pkg::ST_TGAP:   if (out_free) n_state = kwlm_pkg::ST_IDLE;
            kwlm_pkg::ST_NONE:   if (out_free) n_state = kwlm_pkg::ST_IDLE;
            default:             n_state = kwlm_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        n_out   = '0;
        load    = 1'b0;
        o_q_pop = 1'b0;
        unique case (r_state)
            kwlm_pkg::ST_IDLE: o_q_pop = i_q_valid;
            kwlm_pkg::ST_COUNT, kwlm_pkg::ST_TCOUNT: begin
                load        = out_free;
                n_out.kind  = kwlm_pkg::KIND_COUNT;
                n_out.first = r_prev;
                n_out.idx   = r_total - r_start;
                n_out.fin   = (r_state == kwlm_pkg::ST_TCOUNT) && !tail;
            end
            kwlm_pkg::ST_GAP: begin
                load        = out_free;
                n_out.kind  = kwlm_pkg::KIND_GAP;
                n_out.first = r_present ? OW'(prev_inc) : '0;
                n_out.lst   = r_bobj - OW'(1);
            end
            kwlm_pkg::ST_TGAP: begin
                load        = out_free;
                n_out.kind  = kwlm_pkg::KIND_GAP;
                n_out.first = OW'(prev_inc);
                n_out.lst   = OW'(limit - (OW+1)'(1));
                n_out.fin   = 1'b1;
            end
            kwlm_pkg::ST_START: begin
                load        = out_free;
                n_out.kind  = kwlm_pkg::KIND_START;
                n_out.first = r_bobj;
                n_out.idx   = r_total;
            end
            kwlm_pkg::ST_ENTRY: begin
                load       = out_free;
                n_out.kind = kwlm_pkg::KIND_ENTRY;
                n_out.thr  = kwlm_pkg::TID_W'(r_best);
                n_out.ver  = r_bver;
                n_out.mop  = r_bmop;
            end
            kwlm_pkg::ST_NONE: begin
                load       = out_free;
                n_out.kind = kwlm_pkg::KIND_NONE;
                n_out.fin  = 1'b1;
            end
            default: ;
        endcase
    end

    assign clear = load && n_out.fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kwlm_pkg::ST_IDLE;
            r_hvalid    <= '0;
            r_hended    <= '0;
            r_prev      <= '0;
            r_present   <= 1'b0;
            r_total     <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (load) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;

            if (o_q_pop && !r_hvalid[widx] && !r_hended[widx]) begin
                if (i_q_item.cmd == kwlm_pkg::CMD_END) r_hended[widx] <= 1'b1;
                else                                   r_hvalid[widx] <= 1'b1;
            end
            if (r_state == kwlm_pkg::ST_CHECK) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (r_state == kwlm_pkg::ST_SCAN) begin
                r_idx <= r_idx + TW'(1);
                if (better) r_found <= 1'b1;
            end
            if (load && r_state == kwlm_pkg::ST_START) begin
                r_start   <= r_total;
                r_prev    <= r_bobj;
                r_present <= 1'b1;
            end
            if (load && r_state == kwlm_pkg::ST_ENTRY) begin
                if (r_total != '1) r_total <= r_total + NW'(1);
                r_hvalid[r_best] <= 1'b0;
            end
            if (clear) begin
                r_hvalid  <= '0;
                r_hended  <= '0;
                r_prev    <= '0;
                r_present <= 1'b0;
                r_total   <= '0;
                r_start   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // a thread that holds a head or has ended keeps its head untouched
        if (o_q_pop && i_q_item.cmd == kwlm_pkg::CMD_ENTRY &&
                !r_hvalid[widx] && !r_hended[widx]) begin
            r_hobj[widx] <= i_q_item.obj;
            r_hver[widx] <= i_q_item.ver;
            r_hmop[widx] <= i_q_item.mop;
        end
        if (r_state == kwlm_pkg::ST_SCAN && better) begin
            r_best <= r_idx;
            r_bobj <= r_hobj[r_idx];
            r_bver <= r_hver[r_idx];
            r_bmop <= r_hmop[r_idx];
        end
        if (load) r_out <= n_out;
    end

endmodule

// File: rtl/kway_log_merge_indexer.sv
`timescale 1ns / 1ps

// K-way merge of per-thread logs sorted by (object, version), with an
// object index built on the fly. The input side takes one transfer per cycle
// into a two-entry queue, unless the queue is full; items for threads at or
// above the effective thread count are dropped there. The back end pops one
// queued item at a time. When every live thread holds a head or has ended, it
// scans the heads one thread per cycle and then sends 1 to 4 records (count,
// empty range, start, entry). Closing a merge sends 1 or 2 records, the final
// one with last set, after which the head and index state is cleared.
// thread_count and object_count are to be written only while the block is
// idle.
module kway_log_merge_indexer #(
    parameter int MAX_THREADS = kwlm_pkg::MAX_THREADS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kwlm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kwlm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cmd,
    input  logic [kwlm_pkg::TID_W-1:0]        i_thread_id,
    input  logic [kwlm_pkg::OBJ_W-1:0]        i_object_id,
    input  logic [kwlm_pkg::VER_W-1:0]        i_version,
    input  logic [kwlm_pkg::MOP_W-1:0]        i_memop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [kwlm_pkg::KIND_W-1:0]       o_kind,
    output logic [kwlm_pkg::TID_W-1:0]        o_source_thread,
    output logic [kwlm_pkg::VER_W-1:0]        o_out_version,
    output logic [kwlm_pkg::MOP_W-1:0]        o_out_memop,
    output logic [kwlm_pkg::OBJ_W-1:0]        o_range_first,
    output logic [kwlm_pkg::OBJ_W-1:0]        o_range_last,
    output logic [kwlm_pkg::CNT_W-1:0]        o_index_value,
    output logic                              o_last
);

    localparam int CW = $clog2(MAX_THREADS+1);
    localparam int XW = (CW > kwlm_pkg::TC_W) ? CW : kwlm_pkg::TC_W;

    logic [kwlm_pkg::TC_W-1:0] r_tc;
    logic [kwlm_pkg::OC_W-1:0] r_oc;
    logic [CW-1:0]             nt;

    kwlm_pkg::t_item in_item, q_item;
    kwlm_pkg::t_rec  rec;
    logic            q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= kwlm_pkg::TC_W'(1);
            r_oc <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kwlm_pkg::CFG_THREAD_COUNT: r_tc <= i_cfg_data[kwlm_pkg::TC_W-1:0];
                kwlm_pkg::CFG_OBJECT_COUNT: r_oc <= i_cfg_data[kwlm_pkg::OC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective thread count, clamped to 1..MAX_THREADS
    always_comb begin
        if (r_tc == '0)
            nt = CW'(1);
        else if (XW'(r_tc) > XW'(MAX_THREADS))
            nt = CW'(MAX_THREADS);
        else
            nt = CW'(r_tc);
    end

    assign in_item = '{cmd: i_cmd, tid: i_thread_id, obj: i_object_id,
                       ver: i_version, mop: i_memop};

    kwlm_front #(.MAX_THREADS(MAX_THREADS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_nt      (nt),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .o_stall   (o_stall),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    kwlm_back #(.MAX_THREADS(MAX_THREADS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nt           (nt),
        .i_object_count (r_oc),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .o_rec          (rec),
        .i_stall        (i_stall)
    );

    assign o_kind          = rec.kind;
    assign o_source_thread = rec.thr;
    assign o_out_version   = rec.ver;
    assign o_out_memop     = rec.mop;
    assign o_range_first   = rec.first;
    assign o_range_last    = rec.lst;
    assign o_index_value   = rec.idx;
    assign o_last          = rec.fin;

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_kind == kwlm_pkg::KIND_COUNT ||
        o_kind == kwlm_pkg::KIND_GAP || o_kind == kwlm_pkg::KIND_NONE)
        else $error("last flag on a record that cannot close a merge");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == kwlm_pkg::KIND_NONE |-> o_last)
        else $error("no-entries record without last");

    a_entry_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == kwlm_pkg::KIND_ENTRY |->
        o_index_value == '0 && o_range_first == '0 && o_range_last == '0)
        else $error("merged entry carries index fields");

endmodule
